// ===== rtl/core/lte_pkg.sv =====
// types and constants for the load throttle escalation block
// no dependencies; imported by every module under rtl/core
package lte_pkg;

  localparam int LOAD_W    = 16;
  localparam int LIMIT_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_THROTTLED = 2'd1,
    MODE_SUSPENDED = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE           = 3'd0,
    ACT_LOWER          = 3'd1,
    ACT_SUSPEND        = 3'd2,
    ACT_RESUME_RESTORE = 3'd3,
    ACT_RESTORE        = 3'd4
  } action_t;

  typedef enum logic [0:0] {
    OP_SAMPLE  = 1'b0,
    OP_RECOVER = 1'b1
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_LEVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESCALATE_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVER_LEVEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ESCALATE_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVER_LIMIT  = 3'd5;

  localparam logic [LOAD_W-1:0]  THROTTLE_LEVEL_RST = 16'd20480;
  localparam logic [LOAD_W-1:0]  ESCALATE_LEVEL_RST = 16'd24320;
  localparam logic [LOAD_W-1:0]  RECOVER_LEVEL_RST  = 16'd12800;
  localparam logic [LIMIT_W-1:0] THROTTLE_LIMIT_RST = 8'd3;
  localparam logic [LIMIT_W-1:0] ESCALATE_LIMIT_RST = 8'd5;
  localparam logic [LIMIT_W-1:0] RECOVER_LIMIT_RST  = 8'd5;

  typedef struct packed {
    logic              operation;
    logic [LOAD_W-1:0] load_sample;
  } in_item_t;

  typedef struct packed {
    logic              changed;
    logic [1:0]        previous_mode;
    logic [1:0]        current_mode;
    logic [2:0]        action;
    logic [LOAD_W-1:0] reported_load;
  } out_item_t;

  typedef struct packed {
    logic [LOAD_W-1:0]  throttle_level;
    logic [LOAD_W-1:0]  escalate_level;
    logic [LOAD_W-1:0]  recover_level;
    logic [LIMIT_W-1:0] throttle_run_limit;
    logic [LIMIT_W-1:0] escalate_run_limit;
    logic [LIMIT_W-1:0] recover_run_limit;
  } lte_cfg_t;

endpackage

// ===== rtl/core/lte_cfg_regs.sv =====
// configuration register bank: levels and run limits
// depends on lte_pkg
module lte_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lte_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lte_pkg::CFG_DAT_W-1:0]    cfg_wdata,
  output lte_pkg::lte_cfg_t                cfg
);
  import lte_pkg::*;

  lte_cfg_t cfg_r;
  lte_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_THROTTLE_LEVEL: cfg_nxt.throttle_level     = cfg_wdata;
        REG_ESCALATE_LEVEL: cfg_nxt.escalate_level     = cfg_wdata;
        REG_RECOVER_LEVEL:  cfg_nxt.recover_level      = cfg_wdata;
        REG_THROTTLE_LIMIT: cfg_nxt.throttle_run_limit = cfg_wdata[LIMIT_W-1:0];
        REG_ESCALATE_LIMIT: cfg_nxt.escalate_run_limit = cfg_wdata[LIMIT_W-1:0];
        REG_RECOVER_LIMIT:  cfg_nxt.recover_run_limit  = cfg_wdata[LIMIT_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.throttle_level     <= THROTTLE_LEVEL_RST;
      cfg_r.escalate_level     <= ESCALATE_LEVEL_RST;
      cfg_r.recover_level      <= RECOVER_LEVEL_RST;
      cfg_r.throttle_run_limit <= THROTTLE_LIMIT_RST;
      cfg_r.escalate_run_limit <= ESCALATE_LIMIT_RST;
      cfg_r.recover_run_limit  <= RECOVER_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/lte_step.sv =====
// per-item decision logic: run counter updates, mode move and result word
// depends on lte_pkg
module lte_step #(
  parameter int RUN_W = 8
) (
  input  lte_pkg::in_item_t   item,
  input  lte_pkg::lte_cfg_t   cfg,
  input  lte_pkg::mode_t      mode,
  input  logic [RUN_W-1:0]    high_run,
  input  logic [RUN_W-1:0]    critical_run,
  input  logic [RUN_W-1:0]    low_run,
  output lte_pkg::mode_t      mode_nxt,
  output logic [RUN_W-1:0]    high_run_nxt,
  output logic [RUN_W-1:0]    critical_run_nxt,
  output logic [RUN_W-1:0]    low_run_nxt,
  output lte_pkg::out_item_t  result
);
  import lte_pkg::*;

  localparam int CMP_W = (RUN_W > LIMIT_W) ? RUN_W : LIMIT_W;

  logic             is_sample;
  logic             high_hit, crit_hit, low_hit;
  logic [RUN_W-1:0] high_inc, crit_inc, low_inc;
  logic             high_done, crit_done, low_done;
  logic             moved;
  action_t          act;

  assign is_sample = (op_t'(item.operation) == OP_SAMPLE);

  assign high_hit = item.load_sample >= cfg.throttle_level;
  assign crit_hit = item.load_sample >= cfg.escalate_level;
  assign low_hit  = item.load_sample <  cfg.recover_level;

  // saturating run counters
  assign high_inc = !high_hit ? '0 : (&high_run)     ? high_run     : high_run + 1'b1;
  assign crit_inc = !crit_hit ? '0 : (&critical_run) ? critical_run : critical_run + 1'b1;
  assign low_inc  = !low_hit  ? '0 : (&low_run)      ? low_run      : low_run + 1'b1;

  // limit wider than the counter is simply never reached
  assign high_done = CMP_W'(high_inc) >= CMP_W'(cfg.throttle_run_limit);
  assign crit_done = CMP_W'(crit_inc) >= CMP_W'(cfg.escalate_run_limit);
  assign low_done  = CMP_W'(low_inc)  >= CMP_W'(cfg.recover_run_limit);

  // next mode
  always_comb begin
    mode_nxt = mode;
    if (!is_sample) begin
      mode_nxt = MODE_NORMAL;
    end else begin
      case (mode)
        MODE_NORMAL: begin
          if (high_done) mode_nxt = MODE_THROTTLED;
        end
        MODE_THROTTLED: begin
          if (crit_done)     mode_nxt = MODE_SUSPENDED;
          else if (low_done) mode_nxt = MODE_NORMAL;
        end
        MODE_SUSPENDED: begin
          if (low_done) mode_nxt = MODE_NORMAL;
        end
        default: mode_nxt = mode;
      endcase
    end
  end

  assign moved = (mode_nxt != mode);

  // action code and result word
  always_comb begin
    case (mode_nxt)
      MODE_THROTTLED: act = moved ? ACT_LOWER : ACT_NONE;
      MODE_SUSPENDED: act = moved ? ACT_SUSPEND : ACT_NONE;
      MODE_NORMAL: begin
        if (!moved)                      act = ACT_NONE;
        else if (mode == MODE_SUSPENDED) act = ACT_RESUME_RESTORE;
        else                             act = ACT_RESTORE;
      end
      default: act = ACT_NONE;
    endcase
    result.changed       = moved;
    result.previous_mode = mode;
    result.current_mode  = mode_nxt;
    result.action        = act;
    result.reported_load = (moved && is_sample) ? item.load_sample : '0;
  end

  // every move clears the runs; a recover in normal keeps them
  always_comb begin
    if (moved) begin
      high_run_nxt     = '0;
      critical_run_nxt = '0;
      low_run_nxt      = '0;
    end else if (!is_sample) begin
      high_run_nxt     = high_run;
      critical_run_nxt = critical_run;
      low_run_nxt      = low_run;
    end else begin
      high_run_nxt     = high_inc;
      critical_run_nxt = crit_inc;
      low_run_nxt      = low_inc;
    end
  end

endmodule

// ===== rtl/core/load_throttle_escalation_fsm_core.sv =====
// an item passes the input register, then the result register, where its result is valid
// one item per cycle when not stalled; mode and run counters update in the result stage
// the input stage keeps accepting while a result waits, until both registers are full
// reset (rst_n low, synchronous): mode normal, run counters zero, both stages empty,
// configuration registers back to their default levels and limits
module load_throttle_escalation_fsm_core #(
  parameter int RUN_COUNT_WIDTH = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lte_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lte_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [lte_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lte_pkg::CFG_DAT_W-1:0]    cfg_wdata
);
  import lte_pkg::*;

  lte_cfg_t                   cfg;

  logic                       s1_valid_r, s1_valid_nxt;
  in_item_t                   s1_item_r;
  logic                       out_valid_r, out_valid_nxt;
  out_item_t                  out_item_r;

  mode_t                      mode_r, mode_nxt;
  logic [RUN_COUNT_WIDTH-1:0] high_run_r, high_run_nxt;
  logic [RUN_COUNT_WIDTH-1:0] critical_run_r, critical_run_nxt;
  logic [RUN_COUNT_WIDTH-1:0] low_run_r, low_run_nxt;
  out_item_t                  step_result;

  logic                       s1_adv;
  logic                       s1_load;
  logic                       s2_load;

  lte_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lte_step #(
    .RUN_W (RUN_COUNT_WIDTH)
  ) u_step (
    .item             (s1_item_r),
    .cfg              (cfg),
    .mode             (mode_r),
    .high_run         (high_run_r),
    .critical_run     (critical_run_r),
    .low_run          (low_run_r),
    .mode_nxt         (mode_nxt),
    .high_run_nxt     (high_run_nxt),
    .critical_run_nxt (critical_run_nxt),
    .low_run_nxt      (low_run_nxt),
    .result           (step_result)
  );

  // result register frees up when empty or being taken
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign s1_load  = in_valid && in_ready;
  assign s2_load  = s1_valid_r && s1_adv;

  assign s1_valid_nxt  = s1_load || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s2_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      mode_r         <= MODE_NORMAL;
      high_run_r     <= '0;
      critical_run_r <= '0;
      low_run_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s2_load) begin
        mode_r         <= mode_nxt;
        high_run_r     <= high_run_nxt;
        critical_run_r <= critical_run_nxt;
        low_run_r      <= low_run_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item_r <= in_data;
    end
    if (s2_load) begin
      out_item_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

`ifndef SYNTH
  // state register tracks the mode reported in the newest result
  a_mode_matches_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(s2_load) |-> (mode_r == mode_t'(out_item_r.current_mode)))
    else $error("mode register disagrees with last result");

  // a move leaves all run counters cleared
  a_move_clears_runs: assert property (@(posedge clk) disable iff (!rst_n)
    $past(s2_load) && out_item_r.changed |->
      (high_run_r == '0) && (critical_run_r == '0) && (low_run_r == '0))
    else $error("run counters not cleared after a move");

  // input side only stalls when the input register is held
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without a full pipeline");

  // result stage never overwritten while a result is waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_item_r))
    else $error("pending result overwritten");
`endif

endmodule
